[hw/rtl/itrt_pkg.sv]
`timescale 1ns / 1ps
// shared constants, types and the control program of the integer to radix text block
// no dependencies

package itrt_pkg;

    localparam int MAX_DIGITS = 32;
    localparam int VALUE_BITS = 32;

    localparam int RADIX_BITS = 6;
    localparam int CHAR_BITS  = 7;
    localparam int CHUNK_BITS = 8;

    localparam logic [RADIX_BITS-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX     = 6'd36;
    localparam logic [RADIX_BITS-1:0] DECIMAL_LIMIT = 6'd10;
    localparam logic [CHAR_BITS-1:0]  CH_ZERO       = 7'd48;
    localparam logic [CHAR_BITS-1:0]  CH_ALPHA      = 7'd65;
    localparam logic [CHAR_BITS-1:0]  CH_MINUS      = 7'd45;

    localparam int PC_BITS = 3;
    typedef logic [PC_BITS-1:0] t_pc;

    // datapath actions
    typedef logic [2:0] t_act;
    localparam t_act ACT_NONE = 3'd0;
    localparam t_act ACT_LOAD = 3'd1;
    localparam t_act ACT_DIV  = 3'd2;
    localparam t_act ACT_SIGN = 3'd3;
    localparam t_act ACT_READ = 3'd4;
    localparam t_act ACT_EMIT = 3'd5;

    // jump conditions
    typedef logic [2:0] t_cond;
    localparam t_cond C_NEVER      = 3'd0;
    localparam t_cond C_ALWAYS     = 3'd1;
    localparam t_cond C_NO_INPUT   = 3'd2;
    localparam t_cond C_CHUNK_MORE = 3'd3;
    localparam t_cond C_DIGIT_MORE = 3'd4;
    localparam t_cond C_OUT_STALL  = 3'd5;
    localparam t_cond C_COUNT_NZ   = 3'd6;

    // program steps
    localparam t_pc PC_WAIT = 3'd0;
    localparam t_pc PC_DIV  = 3'd1;
    localparam t_pc PC_TEST = 3'd2;
    localparam t_pc PC_SIGN = 3'd3;
    localparam t_pc PC_READ = 3'd4;
    localparam t_pc PC_EMIT = 3'd5;
    localparam t_pc PC_LOOP = 3'd6;
    localparam t_pc PC_DONE = 3'd7;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic chunk_more;
        logic digit_more;
        logic out_stall;
        logic count_nz;
    } t_status;

    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_WAIT: w = '{ACT_LOAD, C_NO_INPUT,   PC_WAIT};
            PC_DIV:  w = '{ACT_DIV,  C_CHUNK_MORE, PC_DIV};
            PC_TEST: w = '{ACT_NONE, C_DIGIT_MORE, PC_DIV};
            PC_SIGN: w = '{ACT_SIGN, C_OUT_STALL,  PC_SIGN};
            PC_READ: w = '{ACT_READ, C_NEVER,      PC_READ};
            PC_EMIT: w = '{ACT_EMIT, C_OUT_STALL,  PC_EMIT};
            PC_LOOP: w = '{ACT_NONE, C_COUNT_NZ,   PC_READ};
            PC_DONE: w = '{ACT_NONE, C_ALWAYS,     PC_WAIT};
            default: w = '{ACT_NONE, C_ALWAYS,     PC_WAIT};
        endcase
        return w;
    endfunction

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [RADIX_BITS-1:0] d);
        if (d < DECIMAL_LIMIT) begin
            return CH_ZERO + CHAR_BITS'(d);
        end
        return CH_ALPHA + CHAR_BITS'(d - DECIMAL_LIMIT);
    endfunction

endpackage

[hw/rtl/itrt_if.sv]
`timescale 1ns / 1ps
// valid/ready channel interfaces for the number input and the character output
// depends on itrt_pkg

interface itrt_in_if #(
    parameter int VALUE_BITS = itrt_pkg::VALUE_BITS
);
    logic                            valid;
    logic                            ready;
    logic signed [VALUE_BITS-1:0]    value;
    logic [itrt_pkg::RADIX_BITS-1:0] radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

interface itrt_out_if;
    logic                           valid;
    logic                           ready;
    logic [itrt_pkg::CHAR_BITS-1:0] char_code;
    logic                           last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

[hw/rtl/itrt_seq.sv]
`timescale 1ns / 1ps
// microcode sequencer: step counter, control rom and jump logic
// depends on itrt_pkg

module itrt_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  itrt_pkg::t_status i_status,
    output itrt_pkg::t_act    o_act
);

    itrt_pkg::t_pc    r_pc;
    itrt_pkg::t_pc    n_pc;
    itrt_pkg::t_uword w;
    logic             taken;

    always_comb begin
        w = itrt_pkg::ucode(r_pc);
        unique case (w.cond)
            itrt_pkg::C_NEVER:      taken = 1'b0;
            itrt_pkg::C_ALWAYS:     taken = 1'b1;
            itrt_pkg::C_NO_INPUT:   taken = ~i_status.in_valid;
            itrt_pkg::C_CHUNK_MORE: taken = i_status.chunk_more;
            itrt_pkg::C_DIGIT_MORE: taken = i_status.digit_more;
            itrt_pkg::C_OUT_STALL:  taken = i_status.out_stall;
            itrt_pkg::C_COUNT_NZ:   taken = i_status.count_nz;
            default:                taken = 1'b1;
        endcase
        n_pc  = taken ? w.target : r_pc + itrt_pkg::PC_BITS'(1);
        o_act = w.act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= itrt_pkg::PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

[hw/rtl/itrt_dp.sv]
`timescale 1ns / 1ps
// datapath: chunked radix divider, digit memory, output register
// depends on itrt_pkg and itrt_if

module itrt_dp #(
    parameter int MAX_DIGITS = itrt_pkg::MAX_DIGITS,
    parameter int VALUE_BITS = itrt_pkg::VALUE_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  itrt_pkg::t_act    i_act,
    output itrt_pkg::t_status o_status,
    itrt_in_if.sink           i_in,
    itrt_out_if.source        o_out
);

    localparam int CB     = itrt_pkg::CHUNK_BITS;
    localparam int RB     = itrt_pkg::RADIX_BITS;
    localparam int CHUNKS = (VALUE_BITS + CB - 1) / CB;
    localparam int QW     = CHUNKS * CB;
    localparam int KW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int AW     = $clog2(MAX_DIGITS);
    localparam int NW     = $clog2(MAX_DIGITS + 1);

    logic [QW-1:0]         r_q;
    logic [RB-1:0]         r_rem;
    logic [RB-1:0]         r_base;
    logic                  r_neg;
    logic [KW-1:0]         r_chunk;
    logic [NW-1:0]         r_count;
    logic [RB-1:0]         r_rd_data;
    logic                  r_out_valid;
    logic [itrt_pkg::CHAR_BITS-1:0] r_out_char;
    logic                  r_out_last;
    logic [RB-1:0]         mem [MAX_DIGITS];

    logic                  accept;
    logic                  chunk_last;
    logic                  out_stall;
    logic                  out_load;
    logic [RB-1:0]         radix_c;
    logic [VALUE_BITS-1:0] mag;
    logic [CB-1:0]         qbits;
    logic [RB-1:0]         rem_c;
    logic [RB:0]           trial;
    logic [NW-1:0]         count_dec;

    assign accept     = i_in.valid & (i_act == itrt_pkg::ACT_LOAD);
    assign i_in.ready = (i_act == itrt_pkg::ACT_LOAD);
    assign chunk_last = (r_chunk == KW'(CHUNKS - 1));
    assign out_stall  = r_out_valid & ~o_out.ready;
    assign out_load   = ~out_stall & (((i_act == itrt_pkg::ACT_SIGN) & r_neg)
                                      | (i_act == itrt_pkg::ACT_EMIT));
    assign count_dec  = r_count - NW'(1);

    assign o_status.in_valid   = i_in.valid;
    assign o_status.chunk_more = ~chunk_last;
    assign o_status.digit_more = (r_q != '0) && (r_count != NW'(MAX_DIGITS));
    assign o_status.out_stall  = out_stall;
    assign o_status.count_nz   = (r_count != '0);

    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_out_char;
    assign o_out.last_char = r_out_last;

    always_comb begin
        if (i_in.radix < itrt_pkg::RADIX_MIN) begin
            radix_c = itrt_pkg::RADIX_MIN;
        end else if (i_in.radix > itrt_pkg::RADIX_MAX) begin
            radix_c = itrt_pkg::RADIX_MAX;
        end else begin
            radix_c = i_in.radix;
        end
        mag = i_in.value[VALUE_BITS-1] ? (~i_in.value + VALUE_BITS'(1)) : i_in.value;
    end

    // one restoring step per quotient bit, one chunk of bits per cycle
    always_comb begin
        rem_c = r_rem;
        qbits = '0;
        for (int i = 0; i < CB; i++) begin
            trial = {rem_c, r_q[QW-1-i]};
            if (trial >= {1'b0, r_base}) begin
                trial        = trial - {1'b0, r_base};
                qbits[CB-1-i] = 1'b1;
            end
            rem_c = trial[RB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_neg       <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_act)
                itrt_pkg::ACT_LOAD: begin
                    if (accept) begin
                        r_q     <= QW'(mag);
                        r_base  <= radix_c;
                        r_neg   <= i_in.value[VALUE_BITS-1];
                        r_rem   <= '0;
                        r_chunk <= '0;
                        r_count <= '0;
                    end
                end
                itrt_pkg::ACT_DIV: begin
                    r_q <= QW'({r_q, qbits});
                    if (chunk_last) begin
                        mem[r_count[AW-1:0]] <= rem_c;
                        r_count <= r_count + NW'(1);
                        r_rem   <= '0;
                        r_chunk <= '0;
                    end else begin
                        r_rem   <= rem_c;
                        r_chunk <= r_chunk + KW'(1);
                    end
                end
                itrt_pkg::ACT_SIGN: begin
                    if (out_load) begin
                        r_out_char  <= itrt_pkg::CH_MINUS;
                        r_out_last  <= 1'b0;
                    end
                end
                itrt_pkg::ACT_READ: begin
                    r_rd_data <= mem[count_dec[AW-1:0]];
                    r_count   <= count_dec;
                end
                itrt_pkg::ACT_EMIT: begin
                    if (out_load) begin
                        r_out_char  <= itrt_pkg::digit_char(r_rd_data);
                        r_out_last  <= (r_count == '0);
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

[hw/rtl/integer_to_radix_text.sv]
`timescale 1ns / 1ps
// integer to radix text: signed integer in, ascii characters out, most significant first
// a new number is taken only after the last character of the previous one is loaded into the output
// a stalled output holds the sequencer at the sign or a digit step; the last character may wait at the output
// synchronous active-low reset returns the sequencer to its wait step and empties the output
// depends on itrt_pkg, itrt_if, itrt_seq, itrt_dp

module integer_to_radix_text #(
    parameter int MAX_DIGITS = itrt_pkg::MAX_DIGITS,
    parameter int VALUE_BITS = itrt_pkg::VALUE_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itrt_in_if.sink    i_in,
    itrt_out_if.source o_out
);

    itrt_pkg::t_act    act;
    itrt_pkg::t_status status;

    itrt_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_act    (act)
    );

    itrt_dp #(
        .MAX_DIGITS (MAX_DIGITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_act    (act),
        .o_status (status),
        .i_in     (i_in),
        .o_out    (o_out)
    );

endmodule
